// File: hdl/bpa_pkg.sv
// Shared constants, codes and controller/datapath interface types of the page allocator.
package bpa_pkg;

    localparam int PAGE_BITS     = 16;
    localparam int LOW_ORDERS    = 15;
    localparam int NORMAL_ORDERS = 16;
    localparam int ORD_W         = 4;
    localparam int CNT_W         = 5;
    localparam int HEAD_W        = PAGE_BITS + 1;
    localparam int HIDX_W        = ORD_W + 1;
    localparam int SIZE_W        = PAGE_BITS + 1;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_REBUILD = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    localparam logic Z_LOW  = 1'b0;
    localparam logic Z_NORM = 1'b1;

    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_TOTAL  = 2'd1;
    localparam logic [1:0] CFG_LOWLIM = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SRCH  = 8'b0000_0010,
        S_POPWR = 8'b0000_0100,
        S_SPLIT = 8'b0000_1000,
        S_FREE  = 8'b0001_0000,
        S_RBCLR = 8'b0010_0000,
        S_RBRUN = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic latch;
        logic search_step;
        logic pop_rd;
        logic pop_wr;
        logic split_push;
        logic free_push;
        logic rb_init;
        logic rb_step;
        logic set_oom;
        logic set_bad;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic ord_bad;
        logic search_end;
        logic hit;
        logic split_end;
        logic free_bad;
        logic rb_end;
        logic out_busy;
    } t_sts;

endpackage

// File: hdl/buddy_page_allocator_top.sv
// Top level of the two-zone page allocator: controller plus datapath.
// Each request gives one result. A successful allocation searches upward from the asked
// order, pops the block found and pushes one split half per order between the two; a failed
// one searches up to the last order of its zone. A rebuild walks the orders of both zones.
// One request is in work at a time; a finished result waits in the output register.
// Reset (synchronous, active low) empties all free lists at once and loads the
// configuration defaults; the link table is not cleared, as every link is written first.
module buddy_page_allocator_top import bpa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_mode,
    input  logic [ORD_W-1:0]     i_block_order,
    input  logic                 i_zone_select,
    input  logic [PAGE_BITS-1:0] i_page_number,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PAGE_BITS-1:0] o_block_page,
    output logic [1:0]           o_status,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    t_cmd cmd;
    t_sts sts;

    // The configuration port never stalls.
    assign pready = 1'b1;

    // The controller takes a request only when idle and steps the datapath
    // through the search, split, free and rebuild sequences.
    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath holds the list heads, the link memory with its registered
    // read port, the configuration registers and the result register.
    bpa_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .i_block_order (i_block_order),
        .i_zone_select (i_zone_select),
        .i_page_number (i_page_number),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_block_page  (o_block_page),
        .o_status      (o_status),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

// File: hdl/bpa_ctrl.sv
// Sequencing state machine of the page allocator.
module bpa_ctrl import bpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_mode,
    output logic       o_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    unique case (i_mode)
                        MODE_ALLOC:   n_state = S_SRCH;
                        MODE_FREE:    n_state = S_FREE;
                        MODE_REBUILD: n_state = S_RBCLR;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_SRCH: begin
                if (i_sts.ord_bad) begin
                    o_cmd.set_bad = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.search_end) begin
                    o_cmd.set_oom = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.hit) begin
                    o_cmd.pop_rd = 1'b1;
                    n_state = S_POPWR;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            S_POPWR: begin
                o_cmd.pop_wr = 1'b1;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (i_sts.split_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.split_push = 1'b1;
                end
            end
            S_FREE: begin
                if (i_sts.free_bad) begin
                    o_cmd.set_bad = 1'b1;
                end else begin
                    o_cmd.free_push = 1'b1;
                end
                n_state = S_DONE;
            end
            S_RBCLR: begin
                o_cmd.rb_init = 1'b1;
                n_state = S_RBRUN;
            end
            S_RBRUN: begin
                if (i_sts.rb_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rb_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_latch_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |=> r_state != S_IDLE)
        else $error("request taken but controller stayed idle");
    a_pop_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop_rd |=> r_state == S_POPWR)
        else $error("link read not followed by head update");
    a_load_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_ready)
        else $error("result loaded but controller not ready");

endmodule

// File: hdl/bpa_dpath.sv
// Datapath of the page allocator: configuration, list heads, link memory and result register.
module bpa_dpath import bpa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    input  logic [ORD_W-1:0]     i_block_order,
    input  logic                 i_zone_select,
    input  logic [PAGE_BITS-1:0] i_page_number,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [PAGE_BITS-1:0] o_block_page,
    output logic [1:0]           o_status,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts
);

    logic [PAGE_BITS-1:0] r_start;
    logic [SIZE_W-1:0]    r_total, r_lowlim;

    logic [HEAD_W-1:0]    r_heads [2**HIDX_W];
    logic [HEAD_W-1:0]    r_links [2**PAGE_BITS];
    logic [HEAD_W-1:0]    r_rdata;

    logic [ORD_W-1:0]     r_ord;
    logic                 r_low_only;
    logic [PAGE_BITS-1:0] r_page;
    logic [CNT_W-1:0]     r_g, r_a, r_ro;
    logic                 r_zone, r_rz;
    logic [PAGE_BITS-1:0] r_got, r_base;
    logic [SIZE_W-1:0]    r_cnt, r_norm_cnt;
    logic [PAGE_BITS-1:0] r_res_page;
    logic [1:0]           r_res_status;
    logic                 r_out_v;
    logic [PAGE_BITS-1:0] r_out_page;
    logic [1:0]           r_out_status;

    logic                 cfg_we;
    logic [HEAD_W-1:0]    head_n, head_l;
    logic                 norm_v, low_v;
    logic [PAGE_BITS-1:0] hit_page;
    logic [CNT_W-1:0]     limit, am1;
    logic                 free_zone;
    logic                 push_en;
    logic [HIDX_W-1:0]    push_idx;
    logic [PAGE_BITS-1:0] push_page;
    logic [SIZE_W-1:0]    start_x, low_sz, norm_sz;
    logic                 rb_bit;

    // Configuration port.
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_total  <= SIZE_W'(65536);
            r_lowlim <= SIZE_W'(32768);
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                CFG_START:  r_start  <= pwdata[PAGE_BITS-1:0];
                CFG_TOTAL:  r_total  <= pwdata[SIZE_W-1:0];
                CFG_LOWLIM: r_lowlim <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            CFG_START:  prdata = 32'(r_start);
            CFG_TOTAL:  prdata = 32'(r_total);
            CFG_LOWLIM: prdata = 32'(r_lowlim);
            default:    prdata = '0;
        endcase
    end

    // Search over orders.
    assign head_n   = r_heads[{Z_NORM, r_g[ORD_W-1:0]}];
    assign head_l   = r_heads[{Z_LOW, r_g[ORD_W-1:0]}];
    assign norm_v   = head_n[PAGE_BITS] && !r_low_only;
    assign low_v    = head_l[PAGE_BITS] && (r_g < CNT_W'(LOW_ORDERS));
    assign hit_page = norm_v ? head_n[PAGE_BITS-1:0] : head_l[PAGE_BITS-1:0];
    assign limit    = r_low_only ? CNT_W'(LOW_ORDERS) : CNT_W'(NORMAL_ORDERS);
    assign am1      = r_a - CNT_W'(1);

    assign free_zone = ({1'b0, r_page} < r_lowlim) ? Z_LOW : Z_NORM;

    // Rebuild sizes.
    assign start_x = {1'b0, r_start};
    always_comb begin
        if (r_total > r_lowlim) begin
            low_sz  = (r_lowlim > start_x) ? r_lowlim - start_x : '0;
            norm_sz = r_total - r_lowlim;
        end else begin
            low_sz  = (r_total > start_x) ? r_total - start_x : '0;
            norm_sz = '0;
        end
    end
    assign rb_bit = r_cnt[r_ro];

    // One push per cycle onto a list head, writing the old head into the link.
    always_comb begin
        push_en   = 1'b0;
        push_idx  = '0;
        push_page = '0;
        if (i_cmd.split_push) begin
            push_en   = 1'b1;
            push_idx  = {r_zone, am1[ORD_W-1:0]};
            push_page = r_got + (PAGE_BITS'(1) << am1[ORD_W-1:0]);
        end else if (i_cmd.free_push) begin
            push_en   = 1'b1;
            push_idx  = {free_zone, r_ord};
            push_page = r_page;
        end else if (i_cmd.rb_step && rb_bit) begin
            push_en   = 1'b1;
            push_idx  = {r_rz, r_ro[ORD_W-1:0]};
            push_page = r_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_links[push_page] <= r_heads[push_idx];
        end
        r_rdata <= r_links[hit_page];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.rb_init) begin
            for (int i = 0; i < 2**HIDX_W; i++) begin
                r_heads[i] <= '0;
            end
        end else if (i_cmd.pop_wr) begin
            r_heads[{r_zone, r_g[ORD_W-1:0]}] <= r_rdata;
        end else if (push_en) begin
            r_heads[push_idx] <= {1'b1, push_page};
        end
    end

    // Item registers and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g  <= '0;
            r_a  <= '0;
            r_ro <= '0;
            r_rz <= Z_LOW;
        end else begin
            if (i_cmd.latch) begin
                r_g <= CNT_W'(i_block_order);
            end else if (i_cmd.search_step) begin
                r_g <= r_g + CNT_W'(1);
            end
            if (i_cmd.pop_wr) begin
                r_a <= r_g;
            end else if (i_cmd.split_push) begin
                r_a <= am1;
            end
            if (i_cmd.rb_init) begin
                r_ro <= '0;
                r_rz <= Z_LOW;
            end else if (i_cmd.rb_step) begin
                if (r_rz == Z_LOW && r_ro == CNT_W'(LOW_ORDERS - 1)) begin
                    r_ro <= '0;
                    r_rz <= Z_NORM;
                end else begin
                    r_ro <= r_ro + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_ord        <= i_block_order;
            r_low_only   <= i_zone_select;
            r_page       <= i_page_number;
            r_res_page   <= '0;
            r_res_status <= ST_OK;
        end
        if (i_cmd.set_oom) begin
            r_res_status <= ST_OOM;
        end else if (i_cmd.set_bad) begin
            r_res_status <= ST_BAD;
        end
        if (i_cmd.pop_rd) begin
            r_zone <= norm_v ? Z_NORM : Z_LOW;
            r_got  <= hit_page;
        end
        if (i_cmd.pop_wr) begin
            r_res_page <= r_got;
        end
        if (i_cmd.rb_init) begin
            r_base     <= r_start;
            r_cnt      <= low_sz;
            r_norm_cnt <= norm_sz;
        end else if (i_cmd.rb_step) begin
            if (r_rz == Z_LOW && r_ro == CNT_W'(LOW_ORDERS - 1)) begin
                r_base <= r_lowlim[PAGE_BITS-1:0];
                r_cnt  <= r_norm_cnt;
            end else if (rb_bit) begin
                r_base <= r_base + (PAGE_BITS'(1) << r_ro[ORD_W-1:0]);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_page   <= r_res_page;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid      = r_out_v;
    assign o_block_page = r_out_page;
    assign o_status     = r_out_status;

    assign o_sts.ord_bad    = {1'b0, r_ord} >= CNT_W'(NORMAL_ORDERS);
    assign o_sts.search_end = r_g >= limit;
    assign o_sts.hit        = norm_v || low_v;
    assign o_sts.split_end  = r_a == {1'b0, r_ord};
    assign o_sts.free_bad   = {1'b0, r_ord} >=
                              ((free_zone == Z_LOW) ? CNT_W'(LOW_ORDERS)
                                                    : CNT_W'(NORMAL_ORDERS));
    assign o_sts.rb_end     = (r_rz == Z_NORM) && (r_ro == CNT_W'(NORMAL_ORDERS));
    assign o_sts.out_busy   = r_out_v && !i_ready;

    a_push_sets_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_en |=> r_heads[$past(push_idx)][PAGE_BITS])
        else $error("pushed list head not marked valid");
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g <= CNT_W'(NORMAL_ORDERS))
        else $error("order search ran past the last order");
    a_low_rebuild_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rz == Z_LOW |-> r_ro < CNT_W'(LOW_ORDERS))
        else $error("low zone rebuild ran past its last order");

endmodule
